// File: sv/lr_action_table_search_assert.svh
// assertion macros for the action table search checker
`ifndef LR_ACTION_TABLE_SEARCH_ASSERT_SVH
`define LR_ACTION_TABLE_SEARCH_ASSERT_SVH

// same-cycle implication, reset masks the check
`define LATS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masks the check
`define LATS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/lats_pkg.sv
// shared types and constants for the action table search block
`default_nettype none

package lats_pkg;

    // memory depth, a power of two, addresses wrap modulo the depth
    localparam int MEM_WORDS_DEFAULT = 4096;

    // fixed field widths
    localparam int ADDR_FIELD_W = 12;
    localparam int WORD_W       = 32;
    localparam int SYM_W        = 16;
    localparam int CFG_DATA_W   = 32;
    localparam int PADDR_W      = 3;

    // signed search bounds, wide enough for any row length plus sign
    localparam int BOUND_W      = WORD_W + 1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_START,
        ST_RD_END,
        ST_ROW,
        ST_PROBE,
        ST_STEP,
        ST_FINAL_SYM,
        ST_FINAL_ACT
    } lats_state_t;

    // one result word
    typedef struct packed {
        logic                    found;
        logic [ADDR_FIELD_W-1:0] entry_offset;
        logic [WORD_W-1:0]       action_word;
    } lats_result_t;

endpackage

`default_nettype wire

// File: sv/lats_ram.sv
// generic single-port ram with registered read
`default_nettype none

module lats_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write or read one word per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// File: sv/lats_search.sv
// search sequencer: write items, offset reads, binary search probes and final check
`default_nettype none

module lats_search #(
    parameter int MEM_WORDS = lats_pkg::MEM_WORDS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic                                kind,
    input  wire logic [lats_pkg::ADDR_FIELD_W-1:0]   write_address,
    input  wire logic [lats_pkg::WORD_W-1:0]         write_word,
    input  wire logic [lats_pkg::ADDR_FIELD_W-1:0]   state_id,
    input  wire logic [lats_pkg::SYM_W-1:0]          symbol_id,
    input  wire logic [lats_pkg::ADDR_FIELD_W-1:0]   table_base,
    output logic                                     busy,
    output logic                                     done,
    output lats_pkg::lats_result_t                   result,
    output logic                                     mem_we,
    output logic [$clog2(MEM_WORDS)-1:0]             mem_addr,
    output logic [lats_pkg::WORD_W-1:0]              mem_wdata,
    input  wire logic [lats_pkg::WORD_W-1:0]         mem_rdata
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam int BW = lats_pkg::BOUND_W;
    localparam int WW = lats_pkg::WORD_W;

    lats_pkg::lats_state_t state_reg, state_next;

    logic [lats_pkg::ADDR_FIELD_W-1:0] sid_reg, sid_next;
    logic [lats_pkg::SYM_W-1:0]        sym_reg, sym_next;
    logic signed [WW-1:0]              start_reg, start_next;
    logic signed [BW-1:0]              count_reg, count_next;
    logic signed [BW-1:0]              lo_reg, lo_next;
    logic signed [BW-1:0]              hi_reg, hi_next;
    logic signed [BW-1:0]              mid_reg, mid_next;
    logic [AW-1:0]                     first_reg, first_next;
    logic                              done_reg, done_next;
    lats_pkg::lats_result_t            res_reg, res_next;

    logic signed [BW-1:0]  row_diff;
    logic signed [BW:0]    bound_sum;
    logic signed [BW-1:0]  mid_c;
    logic signed [BW-1:0]  pos_c;
    logic signed [WW-1:0]  rd_signed;
    logic signed [WW-1:0]  sym_signed;
    logic [AW-1:0]         ofs_addr;
    logic [AW-1:0]         probe_addr;
    logic [AW-1:0]         first_c;

    assign busy   = (state_reg != lats_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    // datapath helpers
    assign rd_signed  = mem_rdata;
    assign sym_signed = WW'(sym_reg);
    assign row_diff   = BW'(rd_signed) - BW'(start_reg);
    assign bound_sum  = (BW+1)'(lo_reg) + (BW+1)'(hi_reg);
    assign mid_c      = bound_sum[BW:1];
    assign pos_c      = hi_reg + BW'(1);
    assign ofs_addr   = AW'(table_base) + AW'(sid_reg);
    assign probe_addr = AW'(start_reg) + AW'({mid_c, 1'b0}) + AW'(1);
    assign first_c    = AW'(start_reg) + AW'({pos_c, 1'b0});

    // state and data registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lats_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sid_reg   <= sid_next;
        sym_reg   <= sym_next;
        start_reg <= start_next;
        count_reg <= count_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        first_reg <= first_next;
        res_reg   <= res_next;
    end

    // next state, memory requests and result
    always_comb
    begin
        state_next = state_reg;
        sid_next   = sid_reg;
        sym_next   = sym_reg;
        start_next = start_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        first_next = first_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_addr   = ofs_addr;
        mem_wdata  = write_word;

        unique case (state_reg)
            lats_pkg::ST_IDLE:
            begin
                mem_addr = AW'(write_address);
                if (start)
                begin
                    if (kind)
                    begin
                        sid_next   = state_id;
                        sym_next   = symbol_id;
                        state_next = lats_pkg::ST_RD_START;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                    end
                end
            end
            lats_pkg::ST_RD_START:
            begin
                mem_addr   = ofs_addr;
                state_next = lats_pkg::ST_RD_END;
            end
            lats_pkg::ST_RD_END:
            begin
                mem_addr   = ofs_addr + AW'(1);
                start_next = rd_signed;
                state_next = lats_pkg::ST_ROW;
            end
            lats_pkg::ST_ROW:
            begin
                // row holds at least one entry when end - start >= 2
                count_next = row_diff >>> 1;
                lo_next    = '0;
                hi_next    = (row_diff >>> 1) - BW'(1);
                if (row_diff > BW'(1))
                begin
                    state_next = lats_pkg::ST_PROBE;
                end
                else
                begin
                    res_next   = '0;
                    done_next  = 1'b1;
                    state_next = lats_pkg::ST_IDLE;
                end
            end
            lats_pkg::ST_PROBE:
            begin
                if (hi_reg >= lo_reg)
                begin
                    mem_addr   = probe_addr;
                    mid_next   = mid_c;
                    state_next = lats_pkg::ST_STEP;
                end
                else if (pos_c < count_reg)
                begin
                    mem_addr   = first_c + AW'(1);
                    first_next = first_c;
                    state_next = lats_pkg::ST_FINAL_SYM;
                end
                else
                begin
                    res_next   = '0;
                    done_next  = 1'b1;
                    state_next = lats_pkg::ST_IDLE;
                end
            end
            lats_pkg::ST_STEP:
            begin
                // lower bound: move right past smaller symbols
                if (rd_signed < sym_signed)
                begin
                    lo_next = mid_reg + BW'(1);
                end
                else
                begin
                    hi_next = mid_reg - BW'(1);
                end
                state_next = lats_pkg::ST_PROBE;
            end
            lats_pkg::ST_FINAL_SYM:
            begin
                mem_addr = first_reg;
                if (rd_signed == sym_signed)
                begin
                    state_next = lats_pkg::ST_FINAL_ACT;
                end
                else
                begin
                    res_next   = '0;
                    done_next  = 1'b1;
                    state_next = lats_pkg::ST_IDLE;
                end
            end
            lats_pkg::ST_FINAL_ACT:
            begin
                res_next.found        = 1'b1;
                res_next.entry_offset = lats_pkg::ADDR_FIELD_W'(first_reg);
                res_next.action_word  = mem_rdata;
                done_next             = 1'b1;
                state_next            = lats_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = lats_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/lr_action_table_search.sv
// top level: lr action row lookup by lower-bound binary search
//
//   channel   handshake               word
//   --------  ----------------------  ------------------------------------------------
//   input     start high, busy low    kind, write_address, write_word, state_id,
//                                     symbol_id
//   result    done pulse, one cycle   found, entry_offset, action_word
//   config    apb write access phase  offset_table_base at byte address 0
//
// a write item: the word goes to memory at the accepting edge
// a lookup reads the row offsets, then binary searches a non-empty row and checks the
// entry found; every step is one access of the single-port table memory
// done pulses the cycle after the last step, busy is low from that cycle on
// rst_n is asynchronous, clears the sequencer and offset_table_base, not memory
// results cannot be stalled; done is shown for exactly one cycle
`default_nettype none

module lr_action_table_search #(
    parameter int MEM_WORDS = lats_pkg::MEM_WORDS_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                kind,
    input  wire logic [lats_pkg::ADDR_FIELD_W-1:0]   write_address,
    input  wire logic signed [lats_pkg::WORD_W-1:0]  write_word,
    input  wire logic [lats_pkg::ADDR_FIELD_W-1:0]   state_id,
    input  wire logic [lats_pkg::SYM_W-1:0]          symbol_id,
    output logic                                     done,
    output logic                                     found,
    output logic [lats_pkg::ADDR_FIELD_W-1:0]        entry_offset,
    output logic signed [lats_pkg::WORD_W-1:0]       action_word,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [lats_pkg::PADDR_W-1:0]        paddr,
    input  wire logic [lats_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [lats_pkg::CFG_DATA_W-1:0]          prdata,
    output logic                                     pready
);

    localparam int AW = $clog2(MEM_WORDS);

    logic [lats_pkg::ADDR_FIELD_W-1:0] base_reg, base_next;
    logic                              reg_sel;
    lats_pkg::lats_result_t            result;
    logic                              mem_we;
    logic [AW-1:0]                     mem_addr;
    logic [lats_pkg::WORD_W-1:0]       mem_wdata;
    logic [lats_pkg::WORD_W-1:0]       mem_rdata;

    // config register decode, word index zero
    assign pready  = 1'b1;
    assign reg_sel = (paddr[lats_pkg::PADDR_W-1] == 1'b0);

    always_comb
    begin
        base_next = base_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            base_next = pwdata[lats_pkg::ADDR_FIELD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
        end
        else
        begin
            base_reg <= base_next;
        end
    end

    // read back
    assign prdata = reg_sel ? lats_pkg::CFG_DATA_W'(base_reg) : '0;

    // table memory
    lats_ram #(
        .WIDTH (lats_pkg::WORD_W),
        .DEPTH (MEM_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // search sequencer
    lats_search #(
        .MEM_WORDS (MEM_WORDS)
    ) u_search (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .kind          (kind),
        .write_address (write_address),
        .write_word    (write_word),
        .state_id      (state_id),
        .symbol_id     (symbol_id),
        .table_base    (base_reg),
        .busy          (busy),
        .done          (done),
        .result        (result),
        .mem_we        (mem_we),
        .mem_addr      (mem_addr),
        .mem_wdata     (mem_wdata),
        .mem_rdata     (mem_rdata)
    );

    // result ports
    assign found        = result.found;
    assign entry_offset = result.entry_offset;
    assign action_word  = result.action_word;

endmodule

`default_nettype wire

// File: sv/lats_checker.sv
// port-level checker for the action table search block, bound to the top level
`default_nettype none

`include "lr_action_table_search_assert.svh"

module lats_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              start,
    input wire logic                              busy,
    input wire logic                              kind,
    input wire logic                              done,
    input wire logic                              found,
    input wire logic [lats_pkg::ADDR_FIELD_W-1:0] entry_offset,
    input wire logic [lats_pkg::WORD_W-1:0]       action_word
);

    // a miss reports zero offset and zero action
    `LATS_ASSERT_NOW(a_miss_zero, clk, rst_n, done && !found, entry_offset == '0 && action_word == '0, "miss with nonzero payload")

    // a result only ends a lookup in progress
    `LATS_ASSERT_NOW(a_done_after_busy, clk, rst_n, done, $past(busy), "result without lookup in progress")

    // a write item gives no result
    `LATS_ASSERT_NEXT(a_write_silent, clk, rst_n, start && !busy && !kind, !done && !busy, "write item produced a result")

    // a lookup holds the block busy
    `LATS_ASSERT_NEXT(a_lookup_busy, clk, rst_n, start && !busy && kind, busy && !done, "lookup did not start")

endmodule

bind lr_action_table_search lats_checker u_lats_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .done         (done),
    .found        (found),
    .entry_offset (entry_offset),
    .action_word  (action_word)
);

`default_nettype wire
